### hdl/pulse_energy_power_meter_unit_macros.svh
// Assertion macros shared by the checker of the pulse energy power meter.
`ifndef PULSE_ENERGY_POWER_METER_UNIT_MACROS_SVH
`define PULSE_ENERGY_POWER_METER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PEPM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pepm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PEPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pepm assertion failed");

`endif

### hdl/pepm_pkg.sv
// Package with the constants and types of the pulse energy power meter.
package pepm_pkg;

	localparam int WIN_DEPTH = 20;
	localparam int SLOT_W    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

	localparam int DEB_W     = 10;
	localparam int PERIOD_W  = 16;
	localparam int MWH_W     = 17;
	localparam int PULSE_W   = 32;
	localparam int ENERGY_W  = 48;
	localparam int VAL_W     = 32;
	localparam int SUM_W     = 40;
	localparam int PROD_W    = 44;

	localparam int DIV_W     = 48;
	localparam int DIVR_W    = 17;
	localparam int DCNT_W    = $clog2(DIV_W + 1);

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MWH      = 8'd2;

	localparam logic [11:0] SEC_PER_HOUR = 12'd3600;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [VAL_W-1:0] sat32(input logic [DIV_W-1:0] v);
		return (|v[DIV_W-1:VAL_W]) ? {VAL_W{1'b1}} : v[VAL_W-1:0];
	endfunction

endpackage

### hdl/pepm_in_if.sv
// Input channel: one millisecond tick with the raw pulse line level.
interface pepm_in_if;
	logic valid;
	logic ready;
	logic raw_level;
	modport source (output valid, output raw_level, input ready);
	modport sink (input valid, input raw_level, output ready);
endinterface

### hdl/pepm_out_if.sv
// Output channel: one result item per tick.
interface pepm_out_if;
	logic        valid;
	logic        ready;
	logic        pulse_edge;
	logic [31:0] total_pulses;
	logic [47:0] total_energy_mwh;
	logic        frame_closed;
	logic [31:0] last_power_w;
	logic [31:0] avg_frame_energy_mwh;
	logic [31:0] avg_power_w;
	modport source (output valid, output pulse_edge, output total_pulses,
		output total_energy_mwh, output frame_closed, output last_power_w,
		output avg_frame_energy_mwh, output avg_power_w, input ready);
	modport sink (input valid, input pulse_edge, input total_pulses,
		input total_energy_mwh, input frame_closed, input last_power_w,
		input avg_frame_energy_mwh, input avg_power_w, output ready);
endinterface

### hdl/pepm_cfg_if.sv
// Configuration write channel: register index and write data.
interface pepm_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  addr;
	logic [31:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

### hdl/pepm_win_ram.sv
// Window memory: frame power and energy per slot, registered read.
module pepm_win_ram (
	input  logic                            clk,
	input  logic                            we,
	input  logic [pepm_pkg::SLOT_W-1:0]     waddr,
	input  logic [2*pepm_pkg::VAL_W-1:0]    wdata,
	input  logic                            re,
	input  logic [pepm_pkg::SLOT_W-1:0]     raddr,
	output logic [2*pepm_pkg::VAL_W-1:0]    rdata
);
	import pepm_pkg::*;

	logic [2*VAL_W-1:0] mem [WIN_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### hdl/pepm_div.sv
// Restoring divider that retires one quotient bit per cycle.
module pepm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pepm_pkg::div_req_t  req,
	output pepm_pkg::div_rsp_t  rsp
);
	import pepm_pkg::*;

	logic [DIV_W-1:0]  quo_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVR_W:0]   rem_sh;
	logic              ge;

	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? DIVR_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIVR_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

### hdl/pulse_energy_power_meter_unit.sv
// Top level of the pulse energy power meter.
// Usage: each input item on in_ch is one millisecond tick carrying the raw
// level of the meter's pulse line. Every tick yields exactly one result item
// on out_ch with the pulse and energy totals and the frame statistics.
// The configuration channel cfg_ch is always ready; index 0 sets the
// debounce time, 1 the stats period and 2 the energy per pulse.
// Sequence: a tick that closes no frame goes from the idle state to ST_OUT
// and then into the output register. A tick that closes a frame runs three
// divisions, one after the other, on one shared serial divider before it
// reaches ST_OUT. The block works on one item at a time, and in_ch is
// ready again as soon as the result is in the output register.
// The window entries live in a small memory read on tick acceptance, ahead
// of the update, so the old entry is at hand when the sums are adjusted.
// Entries beyond the fill count read as zero; no clearing pass is needed.
// Reset loads the register defaults and clears all totals, the frame state
// and the window fill. When the receiver stalls, the result waits in the
// output register and the next tick is still accepted and processed; it
// finishes only once the output register has been taken.
module pulse_energy_power_meter_unit (
	input logic  clk,
	input logic  arst_n,
	pepm_in_if.sink    in_ch,
	pepm_out_if.source out_ch,
	pepm_cfg_if.sink   cfg_ch
);
	import pepm_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_PSTRT = 4'd2;
	localparam logic [3:0] ST_PWAIT = 4'd3;
	localparam logic [3:0] ST_SUM   = 4'd4;
	localparam logic [3:0] ST_ESTRT = 4'd5;
	localparam logic [3:0] ST_EWAIT = 4'd6;
	localparam logic [3:0] ST_ASTRT = 4'd7;
	localparam logic [3:0] ST_AWAIT = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	// Configuration registers.
	logic [DEB_W-1:0]    debounce_q;
	logic [PERIOD_W-1:0] period_q;
	logic [MWH_W-1:0]    mwh_q;

	// Tick state.
	logic [3:0]          state_q;
	logic                stable_q;
	logic                last_raw_q;
	logic [DEB_W-1:0]    ticks_q;
	logic [PULSE_W-1:0]  pulses_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [PERIOD_W-1:0] frame_q;
	logic [ENERGY_W-1:0] start_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [FILL_W-1:0]   fill_q;
	logic [SUM_W-1:0]    esum_q;
	logic [SUM_W-1:0]    psum_q;
	logic [VAL_W-1:0]    avg_e_q;
	logic [VAL_W-1:0]    avg_p_q;
	logic [VAL_W-1:0]    last_pw_q;

	// Work registers of the frame close sequence.
	logic                edge_q;
	logic                closed_q;
	logic [VAL_W-1:0]    fe_q;
	logic [DIVR_W-1:0]   len_q;
	logic [PROD_W-1:0]   prod_q;
	logic [VAL_W-1:0]    pw_q;
	logic [VAL_W-1:0]    nav_e_q;

	// Output register.
	logic                out_valid_q;

	// Held copies so a waiting result does not change under the next item.
	logic [VAL_W-1:0]    last_pw_hold_q;
	logic [VAL_W-1:0]    avg_e_hold_q;
	logic [VAL_W-1:0]    avg_p_hold_q;

	logic                in_fire;
	logic                cfg_fire;
	logic                out_load;

	// Next-tick values computed from the accepted item.
	logic                raw;
	logic [DEB_W-1:0]    ticks_n;
	logic                take_n;
	logic                edge_n;
	logic [PULSE_W-1:0]  pulses_n;
	logic [ENERGY_W:0]   esum_wide;
	logic [ENERGY_W-1:0] energy_n;
	logic [PERIOD_W:0]   elapsed;
	logic                close_n;
	logic [ENERGY_W-1:0] fdiff;

	// Memory and divider signals.
	logic                ram_we;
	logic                ram_re;
	logic [2*VAL_W-1:0]  ram_rdata;
	logic [VAL_W-1:0]    old_e;
	logic [VAL_W-1:0]    old_p;
	logic [SUM_W-1:0]    esum_n;
	logic [SUM_W-1:0]    psum_n;
	logic [FILL_W-1:0]   fill_n;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;

	// Debounce: a level is taken once it has been steady long enough.
	always_comb begin
		raw = in_ch.raw_level;
		if (raw != last_raw_q) begin
			ticks_n = '0;
		end else if (ticks_q != {DEB_W{1'b1}}) begin
			ticks_n = ticks_q + 1'b1;
		end else begin
			ticks_n = ticks_q;
		end
		take_n = (raw != stable_q) && (ticks_n >= debounce_q);
		edge_n = take_n && raw;
	end

	// Totals saturate independently; the frame closes on the tick after the period.
	always_comb begin
		pulses_n  = (edge_n && (pulses_q != {PULSE_W{1'b1}})) ? pulses_q + 1'b1 : pulses_q;
		esum_wide = {1'b0, energy_q} + (ENERGY_W + 1)'(mwh_q);
		if (!edge_n) begin
			energy_n = energy_q;
		end else if (esum_wide[ENERGY_W]) begin
			energy_n = {ENERGY_W{1'b1}};
		end else begin
			energy_n = esum_wide[ENERGY_W-1:0];
		end
		elapsed = {1'b0, frame_q} + 1'b1;
		close_n = elapsed > {1'b0, period_q};
		fdiff   = energy_n - start_q;
	end

	// The old entry counts only once the window has wrapped.
	assign old_e  = (fill_q == FILL_W'(WIN_DEPTH)) ? ram_rdata[VAL_W-1:0] : '0;
	assign old_p  = (fill_q == FILL_W'(WIN_DEPTH)) ? ram_rdata[2*VAL_W-1:VAL_W] : '0;
	assign esum_n = esum_q - SUM_W'(old_e) + SUM_W'(fe_q);
	assign psum_n = psum_q - SUM_W'(old_p) + SUM_W'(pw_q);
	assign fill_n = (fill_q == FILL_W'(WIN_DEPTH)) ? fill_q : fill_q + 1'b1;

	assign ram_re = in_fire;
	assign ram_we = (state_q == ST_SUM);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = {{(DIV_W-PROD_W){1'b0}}, prod_q};
		div_req.divisor  = len_q;
		case (state_q)
			ST_PSTRT: begin
				div_req.start = 1'b1;
			end
			ST_ESTRT: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(esum_q);
				div_req.divisor  = DIVR_W'(fill_q);
			end
			ST_ASTRT: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(psum_q);
				div_req.divisor  = DIVR_W'(fill_q);
			end
			default: begin
			end
		endcase
	end

	pepm_win_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata ({pw_q, fe_q}),
		.re    (ram_re),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	pepm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEB_W'(25);
			period_q    <= PERIOD_W'(250);
			mwh_q       <= MWH_W'(500);
			state_q     <= ST_IDLE;
			stable_q    <= 1'b1;
			last_raw_q  <= 1'b1;
			ticks_q     <= '0;
			pulses_q    <= '0;
			energy_q    <= '0;
			frame_q     <= '0;
			start_q     <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			esum_q      <= '0;
			psum_q      <= '0;
			avg_e_q     <= '0;
			avg_p_q     <= '0;
			last_pw_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				case (cfg_ch.addr)
					CFG_DEBOUNCE: debounce_q <= cfg_ch.data[DEB_W-1:0];
					CFG_PERIOD:   period_q   <= cfg_ch.data[PERIOD_W-1:0];
					CFG_MWH:      mwh_q      <= cfg_ch.data[MWH_W-1:0];
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						last_raw_q <= raw;
						ticks_q    <= ticks_n;
						if (take_n) begin
							stable_q <= raw;
						end
						pulses_q <= pulses_n;
						energy_q <= energy_n;
						frame_q  <= close_n ? '0 : elapsed[PERIOD_W-1:0];
						if (close_n) begin
							start_q <= energy_n;
						end
						state_q <= close_n ? ST_MUL : ST_OUT;
					end
				end
				ST_MUL:   state_q <= ST_PSTRT;
				ST_PSTRT: state_q <= ST_PWAIT;
				ST_PWAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					esum_q  <= esum_n;
					psum_q  <= psum_n;
					fill_q  <= fill_n;
					slot_q  <= (slot_q == SLOT_W'(WIN_DEPTH - 1)) ? '0 : slot_q + 1'b1;
					state_q <= ST_ESTRT;
				end
				ST_ESTRT: state_q <= ST_EWAIT;
				ST_EWAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_ASTRT;
					end
				end
				ST_ASTRT: state_q <= ST_AWAIT;
				ST_AWAIT: begin
					if (div_rsp.done) begin
						avg_p_q   <= sat32(div_rsp.quotient);
						avg_e_q   <= nav_e_q;
						last_pw_q <= pw_q;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload of the frame close sequence.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			edge_q   <= edge_n;
			closed_q <= close_n;
			fe_q     <= sat32(fdiff);
			len_q    <= elapsed;
		end
		if (state_q == ST_MUL) begin
			prod_q <= fe_q * SEC_PER_HOUR;
		end
		if ((state_q == ST_PWAIT) && div_rsp.done) begin
			pw_q <= sat32(div_rsp.quotient);
		end
		if ((state_q == ST_EWAIT) && div_rsp.done) begin
			nav_e_q <= sat32(div_rsp.quotient);
		end
	end

	// Output register; the averages and last power go out through the held copies below.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.pulse_edge       <= edge_q;
			out_ch.total_pulses     <= pulses_q;
			out_ch.total_energy_mwh <= energy_q;
			out_ch.frame_closed     <= closed_q;
		end
	end

	assign out_ch.valid                = out_valid_q;
	assign out_ch.last_power_w         = last_pw_hold_q;
	assign out_ch.avg_frame_energy_mwh = avg_e_hold_q;
	assign out_ch.avg_power_w          = avg_p_hold_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			last_pw_hold_q <= last_pw_q;
			avg_e_hold_q   <= avg_e_q;
			avg_p_hold_q   <= avg_p_q;
		end
	end
endmodule

### hdl/pepm_checker.sv
// Port checker for the pulse energy power meter and its bind statement.
`include "pulse_energy_power_meter_unit_macros.svh"

module pepm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        pulse_edge,
	input logic [31:0] total_pulses
);
	`PEPM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`PEPM_ASSERT_NOW(a_edge_counts, clk, arst_n, out_valid && pulse_edge, total_pulses != 32'd0)
	`PEPM_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
endmodule

bind pulse_energy_power_meter_unit pepm_checker u_pepm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.pulse_edge   (out_ch.pulse_edge),
	.total_pulses (out_ch.total_pulses)
);

### tb/pepm_meter_checker.sv
// Checker that predicts every result item of the pulse energy power meter and compares it.
module pepm_meter_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  logic in_raw_level,
	input  logic out_valid,
	input  logic out_ready,
	input  logic out_pulse_edge,
	input  logic [pepm_pkg::PULSE_W-1:0] out_total_pulses,
	input  logic [pepm_pkg::ENERGY_W-1:0] out_total_energy_mwh,
	input  logic out_frame_closed,
	input  logic [pepm_pkg::VAL_W-1:0] out_last_power_w,
	input  logic [pepm_pkg::VAL_W-1:0] out_avg_frame_energy_mwh,
	input  logic [pepm_pkg::VAL_W-1:0] out_avg_power_w,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [pepm_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [pepm_pkg::CFG_DATA_W-1:0] cfg_data,
	output int   pending,
	output int   failures
);
	timeunit 1ns;
	timeprecision 1ps;
	import pepm_pkg::*;

	typedef struct packed {
		logic                pulse_edge;
		logic [PULSE_W-1:0]  total_pulses;
		logic [ENERGY_W-1:0] total_energy_mwh;
		logic                frame_closed;
		logic [VAL_W-1:0]    last_power_w;
		logic [VAL_W-1:0]    avg_energy;
		logic [VAL_W-1:0]    avg_power;
	} meter_reading_t;

	meter_reading_t readings_due[$];

	logic [DEB_W-1:0]    debounce_ticks;
	logic [PERIOD_W-1:0] period_ticks;
	logic [MWH_W-1:0]    energy_per_pulse;

	logic                line_level;
	logic                prev_raw;
	logic [DEB_W-1:0]    steady_count;
	logic [PULSE_W-1:0]  pulse_count;
	logic [ENERGY_W-1:0] energy_mwh;
	logic [PERIOD_W-1:0] ticks_in_frame;
	logic [ENERGY_W-1:0] frame_base_mwh;
	logic [VAL_W-1:0]    energy_hist [WIN_DEPTH];
	logic [VAL_W-1:0]    power_hist [WIN_DEPTH];
	logic [63:0]         energy_hist_sum;
	logic [63:0]         power_hist_sum;
	int                  hist_slot;
	int                  hist_fill;
	logic [VAL_W-1:0]    avg_energy_held;
	logic [VAL_W-1:0]    avg_power_held;
	logic [VAL_W-1:0]    power_held;

	function automatic logic [VAL_W-1:0] clip32(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? {VAL_W{1'b1}} : v[VAL_W-1:0];
	endfunction

	// Advances the meter by one tick and returns the reading it produces.
	function automatic meter_reading_t meter_tick(input logic raw);
		meter_reading_t r;
		logic [63:0] elapsed;
		logic [63:0] frame_mwh;
		logic [63:0] energy_sum;
		logic [VAL_W-1:0] fe;
		logic [VAL_W-1:0] pw;
		r = '0;
		if (raw != prev_raw) begin
			prev_raw = raw;
			steady_count = '0;
		end else if (steady_count != 10'd1023) begin
			steady_count++;
		end
		if (raw != line_level && steady_count >= debounce_ticks) begin
			line_level = raw;
			r.pulse_edge = raw;
		end
		if (r.pulse_edge) begin
			if (pulse_count != 32'hFFFF_FFFF)
				pulse_count++;
			energy_sum = 64'(energy_mwh) + 64'(energy_per_pulse);
			energy_mwh = (energy_sum > 64'hFFFF_FFFF_FFFF) ? {ENERGY_W{1'b1}}
				: energy_sum[ENERGY_W-1:0];
		end
		elapsed = 64'(ticks_in_frame) + 1;
		if (elapsed > 64'(period_ticks)) begin
			frame_mwh = 64'(energy_mwh - frame_base_mwh);
			fe = clip32(frame_mwh);
			pw = clip32((64'(fe) * 64'd3600) / elapsed);
			energy_hist_sum = energy_hist_sum - energy_hist[hist_slot] + fe;
			power_hist_sum = power_hist_sum - power_hist[hist_slot] + pw;
			energy_hist[hist_slot] = fe;
			power_hist[hist_slot] = pw;
			hist_slot = (hist_slot + 1) % WIN_DEPTH;
			if (hist_fill < WIN_DEPTH)
				hist_fill++;
			power_held = pw;
			avg_energy_held = clip32(energy_hist_sum / hist_fill);
			avg_power_held = clip32(power_hist_sum / hist_fill);
			frame_base_mwh = energy_mwh;
			ticks_in_frame = '0;
			r.frame_closed = 1'b1;
		end else begin
			ticks_in_frame = elapsed[PERIOD_W-1:0];
		end
		r.total_pulses = pulse_count;
		r.total_energy_mwh = energy_mwh;
		r.last_power_w = power_held;
		r.avg_energy = avg_energy_held;
		r.avg_power = avg_power_held;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			failures++;
			if (failures <= 10)
				$display("mismatch in %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	initial begin
		pending = 0;
		failures = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		meter_reading_t want;
		if (!arst_n) begin
			debounce_ticks = 10'd25;
			period_ticks = 16'd250;
			energy_per_pulse = 17'd500;
			line_level = 1'b1;
			prev_raw = 1'b1;
			steady_count = '0;
			pulse_count = '0;
			energy_mwh = '0;
			ticks_in_frame = '0;
			frame_base_mwh = '0;
			for (int i = 0; i < WIN_DEPTH; i++) begin
				energy_hist[i] = '0;
				power_hist[i] = '0;
			end
			energy_hist_sum = '0;
			power_hist_sum = '0;
			hist_slot = 0;
			hist_fill = 0;
			avg_energy_held = '0;
			avg_power_held = '0;
			power_held = '0;
			readings_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					CFG_DEBOUNCE: debounce_ticks = cfg_data[DEB_W-1:0];
					CFG_PERIOD:   period_ticks = cfg_data[PERIOD_W-1:0];
					CFG_MWH:      energy_per_pulse = cfg_data[MWH_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				readings_due.push_back(meter_tick(in_raw_level));
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("result item arrived with none expected");
				end else begin
					want = readings_due.pop_front();
					check_field("pulse_edge", 64'(want.pulse_edge), 64'(out_pulse_edge));
					check_field("total_pulses", 64'(want.total_pulses),
						64'(out_total_pulses));
					check_field("total_energy_mwh", 64'(want.total_energy_mwh),
						64'(out_total_energy_mwh));
					check_field("frame_closed", 64'(want.frame_closed),
						64'(out_frame_closed));
					check_field("last_power_w", 64'(want.last_power_w),
						64'(out_last_power_w));
					check_field("avg_frame_energy_mwh", 64'(want.avg_energy),
						64'(out_avg_frame_energy_mwh));
					check_field("avg_power_w", 64'(want.avg_power), 64'(out_avg_power_w));
				end
			end
		end
		pending = readings_due.size();
	end

endmodule

### tb/pulse_energy_power_meter_unit_tb.sv
// Testbench top: drives ticks and register writes into the meter and gives the verdict.
module pulse_energy_power_meter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pepm_pkg::*;

	logic clk;
	logic arst_n;
	int   pending;
	int   failures;
	int   ticks_sent;

	pepm_in_if  in_ch ();
	pepm_out_if out_ch ();
	pepm_cfg_if cfg_ch ();

	pulse_energy_power_meter_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg_ch (cfg_ch.sink)
	);

	pepm_meter_checker i_checker (
		.clk                      (clk),
		.arst_n                   (arst_n),
		.in_valid                 (in_ch.valid),
		.in_ready                 (in_ch.ready),
		.in_raw_level             (in_ch.raw_level),
		.out_valid                (out_ch.valid),
		.out_ready                (out_ch.ready),
		.out_pulse_edge           (out_ch.pulse_edge),
		.out_total_pulses         (out_ch.total_pulses),
		.out_total_energy_mwh     (out_ch.total_energy_mwh),
		.out_frame_closed         (out_ch.frame_closed),
		.out_last_power_w         (out_ch.last_power_w),
		.out_avg_frame_energy_mwh (out_ch.avg_frame_energy_mwh),
		.out_avg_power_w          (out_ch.avg_power_w),
		.cfg_valid                (cfg_ch.valid),
		.cfg_ready                (cfg_ch.ready),
		.cfg_addr                 (cfg_ch.addr),
		.cfg_data                 (cfg_ch.data),
		.pending                  (pending),
		.failures                 (failures)
	);

	// Free-running clock with a 20 ns period.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// The receiver stalls about one cycle in five, except for a long calm
	// stretch of items in the middle of the run where it always takes the result.
	always @(posedge clk) begin
		if (ticks_sent >= 330 && ticks_sent < 450)
			out_ch.ready <= 1'b1;
		else
			out_ch.ready <= ($urandom_range(99) >= 21);
	end

	// Hands one tick to the block. The sender idles now and then, but not
	// during a calm stretch of items. Valid stays high after acceptance so
	// that back-to-back ticks need no second assignment in one time step.
	task automatic send_tick(input logic lvl);
		if (!(ticks_sent >= 330 && ticks_sent < 450) && $urandom_range(99) < 21) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.raw_level <= lvl;
		do @(posedge clk); while (!in_ch.ready);
		ticks_sent++;
	endtask

	// Stops sending and waits until every expected result item has come back.
	task automatic drain;
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Produces a tick stream made of level runs. Most runs outlast the
	// debounce time so that real pulses get counted; the rest are glitches
	// shorter than the debounce time, or single ticks of noise.
	task automatic send_runs(input int count, input int deb);
		logic lvl;
		int   run;
		lvl = $urandom_range(1);
		while (count > 0) begin
			case ($urandom_range(9))
				0:       run = 1;
				1, 2:    run = $urandom_range(1, (deb > 0) ? deb : 1);
				default: run = deb + $urandom_range(1, 6);
			endcase
			for (int i = 0; i < run && count > 0; i++) begin
				send_tick(lvl);
				count--;
			end
			lvl = !lvl;
		end
	endtask

	// Register settings per random phase: debounce, period, energy per pulse.
	int phase_deb [6] = '{3, 0, 1023, 5, 2, 10};
	int phase_per [6] = '{20, 0, 1, 65535, 7, 100};
	int phase_mwh [6] = '{500, 100000, 1, 7, 131071, 1};

	initial begin
		in_ch.valid = 1'b0;
		in_ch.raw_level = 1'b1;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.addr = '0;
		cfg_ch.data = '0;
		ticks_sent = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: a short low glitch is filtered by the debounce.
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		drain();

		// No debounce, a frame on every tick, and the largest pulse energy;
		// upper data bits beyond each register's width must be dropped.
		write_reg(CFG_DEBOUNCE, 32'hFFFF_FC00);
		write_reg(CFG_PERIOD, 32'hABCD_0000);
		write_reg(CFG_MWH, 32'hFFFF_FFFF);
		for (int i = 0; i < 10; i++)
			send_tick(i[0]);
		drain();

		// Debounce set to one tick, period set to two: glitches, then pulses.
		write_reg(CFG_DEBOUNCE, 32'd1);
		write_reg(CFG_PERIOD, 32'd2);
		write_reg(CFG_MWH, 32'd1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		drain();

		// Random phases, each with its own register setting.
		for (int p = 0; p < 6; p++) begin
			write_reg(CFG_DEBOUNCE, phase_deb[p]);
			write_reg(CFG_PERIOD, phase_per[p]);
			write_reg(CFG_MWH, phase_mwh[p]);
			send_runs(115, phase_deb[p]);
			drain();
		end

		repeat (400) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#60_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
